/* hw/rtl/sti_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the sorted key table: opcodes, status codes, command and status bundles.
package sti_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [6:0] CAPACITY_RESET = 7'd64;

    // Read address source for the table memory
    typedef enum logic [2:0] {
        RA_POS    = 3'd0,
        RA_CNT_M1 = 3'd1,
        RA_IDX_M2 = 3'd2,
        RA_IDX_P1 = 3'd3,
        RA_IDX_P2 = 3'd4
    } rd_sel_t;

    // Write data source for the table memory
    typedef enum logic {
        WD_RDATA = 1'b0,
        WD_KEY   = 1'b1
    } wr_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD = 3'd0,
        IDX_POS  = 3'd1,
        IDX_CNT  = 3'd2,
        IDX_DEC  = 3'd3,
        IDX_INC  = 3'd4
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    typedef enum logic [1:0] {
        OK_ZERO  = 2'd0,
        OK_RDATA = 2'd1,
        OK_HOLD  = 2'd2
    } okey_sel_t;

    typedef struct packed {
        logic       load_key;
        logic       hold_key;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        wr_sel_t    wr_sel;
        idx_op_t    idx_op;
        logic       finish;
        logic [1:0] res_status;
        okey_sel_t  okey_sel;
        cnt_op_t    cnt_op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic full;
        logic pos_bad;
        logic cnt_zero;
        logic ge;
        logic idx_is_one;
        logic more1;
        logic more2;
    } dp_sts_t;

endpackage

/* hw/rtl/sorted_table_insert_remove.sv */
`timescale 1ns / 1ps
// Top level of the sorted key table with insert, lookup and remove operations.
//
// Usage: each input item is one operation (opcode 0 insert key_in, 1 lookup at
// position, 2 remove at position, 3 no operation) and yields exactly one result
// item carrying key_out, status (0 ok, 1 full, 2 index out of range) and the
// entry_count after the operation. Keys are kept in ascending order; a new key
// goes in front of any equal keys.
// Sequence: rejected and no-operation items finish straight from idle; a lookup
// reads the entry and returns it; an insert moves each larger or equal entry up,
// then writes the key; a remove moves later entries down. The table memory has
// one write and one registered read port, so the walk moves one entry a cycle.
// One item is in work at a time; the result sits in an output register, so a
// new item is taken while the previous result waits as long as it is being
// taken in the same cycle or the register is empty.
// Reset: the table is empty and capacity is 64; table contents are not cleared.
// Stall: a stalled result holds, and no further item is taken until it drains.
// cfg_wen/cfg_wdata write the capacity register; write only while idle.
module sorted_table_insert_remove #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] key_in,
    input  logic [5:0]  position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] key_out,
    output logic [1:0]  status,
    output logic [6:0]  entry_count,
    input  logic        cfg_wen,
    input  logic [6:0]  cfg_wdata
);

    sti_pkg::dp_cmd_t cmd;
    sti_pkg::dp_sts_t sts;

    // Sequencing of each operation's memory walk
    sti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Table storage, count, capacity and result register
    sti_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_in      (key_in),
        .position    (position),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .key_out     (key_out),
        .status      (status),
        .entry_count (entry_count),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

/* hw/rtl/sti_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
module sti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

/* hw/rtl/sti_dp.sv */
`timescale 1ns / 1ps
// Datapath of the sorted key table: table memory, count, capacity, walk index and result register.
module sti_dp #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      key_in,
    input  logic [5:0]       position,
    input  logic             cfg_wen,
    input  logic [6:0]       cfg_wdata,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [31:0]      key_out,
    output logic [1:0]       status,
    output logic [6:0]       entry_count,
    input  sti_pkg::dp_cmd_t cmd,
    output sti_pkg::dp_sts_t sts
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CW1   = CW + 1;
    localparam int CMP_W = (CW > 7) ? CW : 7;

    logic [CW-1:0]        count_reg, count_next;
    logic [6:0]           capacity_reg, capacity_next;
    logic                 out_valid_reg, out_valid_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [KEY_WIDTH-1:0] key_hold_reg, key_hold_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [31:0]          key_out_reg, key_out_next;
    logic [1:0]           status_reg, status_next;
    logic [6:0]           entry_count_reg, entry_count_next;

    logic [AW-1:0]        rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;
    logic [KEY_WIDTH-1:0] wr_data;
    logic [KEY_WIDTH-1:0] okey;
    logic [CMP_W-1:0]     count_ext;
    logic                 full;

    assign count_ext = CMP_W'(count_reg);
    assign full      = (count_ext >= CMP_W'(capacity_reg)) || (count_ext >= CMP_W'(DEPTH));

    always_comb
    begin
        sts.out_free   = !out_valid_reg || !out_stall;
        sts.full       = full;
        sts.pos_bad    = CMP_W'(position) >= count_ext;
        sts.cnt_zero   = (count_reg == '0);
        sts.ge         = (rd_data >= key_reg);
        sts.idx_is_one = (idx_reg == CW'(1));
        sts.more1      = (CW1'(idx_reg) + CW1'(1)) < CW1'(count_reg);
        sts.more2      = (CW1'(idx_reg) + CW1'(2)) < CW1'(count_reg);
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            sti_pkg::RA_POS:    rd_addr = AW'(position);
            sti_pkg::RA_CNT_M1: rd_addr = AW'(count_reg - CW'(1));
            sti_pkg::RA_IDX_M2: rd_addr = AW'(idx_reg - CW'(2));
            sti_pkg::RA_IDX_P1: rd_addr = AW'(idx_reg + CW'(1));
            sti_pkg::RA_IDX_P2: rd_addr = AW'(idx_reg + CW'(2));
            default:            rd_addr = AW'(position);
        endcase
    end

    assign wr_data = (cmd.wr_sel == sti_pkg::WD_KEY) ? key_reg : rd_data;

    sti_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (cmd.okey_sel)
            sti_pkg::OK_RDATA: okey = rd_data;
            sti_pkg::OK_HOLD:  okey = key_hold_reg;
            default:           okey = '0;
        endcase
    end

    always_comb
    begin
        key_next      = cmd.load_key ? KEY_WIDTH'(key_in) : key_reg;
        key_hold_next = cmd.hold_key ? rd_data : key_hold_reg;
        capacity_next = cfg_wen ? cfg_wdata : capacity_reg;

        case (cmd.idx_op)
            sti_pkg::IDX_POS: idx_next = CW'(position);
            sti_pkg::IDX_CNT: idx_next = count_reg;
            sti_pkg::IDX_DEC: idx_next = idx_reg - CW'(1);
            sti_pkg::IDX_INC: idx_next = idx_reg + CW'(1);
            default:          idx_next = idx_reg;
        endcase

        case (cmd.cnt_op)
            sti_pkg::CNT_INC: count_next = count_reg + CW'(1);
            sti_pkg::CNT_DEC: count_next = count_reg - CW'(1);
            default:          count_next = count_reg;
        endcase

        // Load the result on finish; drop it once taken
        out_valid_next   = cmd.finish || (out_valid_reg && out_stall);
        key_out_next     = cmd.finish ? 32'(okey) : key_out_reg;
        status_next      = cmd.finish ? cmd.res_status : status_reg;
        entry_count_next = cmd.finish ? 7'(count_next) : entry_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            capacity_reg  <= sti_pkg::CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        key_hold_reg    <= key_hold_next;
        idx_reg         <= idx_next;
        key_out_reg     <= key_out_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign key_out     = key_out_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_op == sti_pkg::CNT_INC) |-> !full)
        else $error("count advanced on a full table");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (idx_reg < CW'(DEPTH)))
        else $error("table write beyond depth");

endmodule

/* hw/rtl/sti_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the sorted key table: sequences insert walks, lookups and remove walks.
module sti_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       opcode,
    output logic             in_stall,
    output sti_pkg::dp_cmd_t cmd,
    input  sti_pkg::dp_sts_t sts
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_INS_CMP  = 6'b000010,
        S_INS_PUT  = 6'b000100,
        S_LOOKUP   = 6'b001000,
        S_RM_FIRST = 6'b010000,
        S_RM_SHIFT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_stall = !((state_reg == S_IDLE) && sts.out_free);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = sti_pkg::RA_POS;
        cmd.wr_sel     = sti_pkg::WD_RDATA;
        cmd.idx_op     = sti_pkg::IDX_HOLD;
        cmd.res_status = sti_pkg::ST_OK;
        cmd.okey_sel   = sti_pkg::OK_ZERO;
        cmd.cnt_op     = sti_pkg::CNT_HOLD;
        cmd.load_key   = accept;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        sti_pkg::OP_INSERT:
                        begin
                            if (sts.full)
                            begin
                                cmd.finish     = 1'b1;
                                cmd.res_status = sti_pkg::ST_FULL;
                            end
                            else if (sts.cnt_zero)
                            begin
                                cmd.idx_op = sti_pkg::IDX_CNT;
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                cmd.idx_op = sti_pkg::IDX_CNT;
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = sti_pkg::RA_CNT_M1;
                                state_next = S_INS_CMP;
                            end
                        end
                        sti_pkg::OP_LOOKUP:
                        begin
                            if (sts.pos_bad)
                            begin
                                cmd.finish     = 1'b1;
                                cmd.res_status = sti_pkg::ST_RANGE;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                state_next = S_LOOKUP;
                            end
                        end
                        sti_pkg::OP_REMOVE:
                        begin
                            if (sts.pos_bad)
                            begin
                                cmd.finish     = 1'b1;
                                cmd.res_status = sti_pkg::ST_RANGE;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.idx_op = sti_pkg::IDX_POS;
                                state_next = S_RM_FIRST;
                            end
                        end
                        default:
                        begin
                            cmd.finish = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.ge)
                begin
                    // Shift the larger or equal entry up one slot and step down
                    cmd.wr_sel = sti_pkg::WD_RDATA;
                    cmd.idx_op = sti_pkg::IDX_DEC;
                    if (sts.idx_is_one)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = sti_pkg::RA_IDX_M2;
                    end
                end
                else
                begin
                    cmd.wr_sel = sti_pkg::WD_KEY;
                    cmd.finish = 1'b1;
                    cmd.cnt_op = sti_pkg::CNT_INC;
                    state_next = S_IDLE;
                end
            end
            S_INS_PUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = sti_pkg::WD_KEY;
                cmd.finish = 1'b1;
                cmd.cnt_op = sti_pkg::CNT_INC;
                state_next = S_IDLE;
            end
            S_LOOKUP:
            begin
                cmd.finish   = 1'b1;
                cmd.okey_sel = sti_pkg::OK_RDATA;
                state_next   = S_IDLE;
            end
            S_RM_FIRST:
            begin
                cmd.hold_key = 1'b1;
                if (sts.more1)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sti_pkg::RA_IDX_P1;
                    state_next = S_RM_SHIFT;
                end
                else
                begin
                    cmd.finish   = 1'b1;
                    cmd.okey_sel = sti_pkg::OK_RDATA;
                    cmd.cnt_op   = sti_pkg::CNT_DEC;
                    state_next   = S_IDLE;
                end
            end
            S_RM_SHIFT:
            begin
                // Move the next entry down one slot
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = sti_pkg::WD_RDATA;
                cmd.idx_op = sti_pkg::IDX_INC;
                if (sts.more2)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sti_pkg::RA_IDX_P2;
                end
                else
                begin
                    cmd.finish   = 1'b1;
                    cmd.okey_sel = sti_pkg::OK_HOLD;
                    cmd.cnt_op   = sti_pkg::CNT_DEC;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("result produced while output register occupied");

    a_put_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_PUT) |=> (state_reg == S_IDLE))
        else $error("insert did not complete after placing key");

endmodule
